FILE: src/erpu_pkg.sv
// ----------------------------------------------------------------------------
// erpu_pkg
// shared types and codes for the elf relocation patch unit
// ----------------------------------------------------------------------------
package erpu_pkg;

   // standard elf relocation type codes
   localparam logic [31:0] RT_X86_64_NONE     = 32'd0;
   localparam logic [31:0] RT_X86_64_64       = 32'd1;
   localparam logic [31:0] RT_X86_64_PC32     = 32'd2;
   localparam logic [31:0] RT_X86_64_PLT32    = 32'd4;
   localparam logic [31:0] RT_X86_64_32       = 32'd10;
   localparam logic [31:0] RT_X86_64_32S      = 32'd11;
   localparam logic [31:0] RT_X86_64_PC64     = 32'd24;
   localparam logic [31:0] RT_A64_ABS64       = 32'd257;
   localparam logic [31:0] RT_A64_ABS32       = 32'd258;
   localparam logic [31:0] RT_A64_PREL32      = 32'd261;
   localparam logic [31:0] RT_A64_ADR_PG_HI21 = 32'd275;
   localparam logic [31:0] RT_A64_ADD_LO12    = 32'd277;
   localparam logic [31:0] RT_A64_LDST8_LO12  = 32'd278;
   localparam logic [31:0] RT_A64_CONDBR19    = 32'd280;
   localparam logic [31:0] RT_A64_JUMP26      = 32'd282;
   localparam logic [31:0] RT_A64_CALL26      = 32'd283;
   localparam logic [31:0] RT_A64_LDST32_LO12 = 32'd285;
   localparam logic [31:0] RT_A64_LDST64_LO12 = 32'd286;
   localparam logic [31:0] RT_A64_RELATIVE    = 32'd1027;

   // write sizes
   localparam logic [3:0] BYTES_NONE  = 4'd0;
   localparam logic [3:0] BYTES_WORD  = 4'd4;
   localparam logic [3:0] BYTES_DWORD = 4'd8;

   // depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_ALIGN   = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   // operation class picked by the front
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ABS64,
      OP_PC64,
      OP_ABS32U,
      OP_ABS32S,
      OP_PC32,
      OP_BR26,
      OP_BR19,
      OP_ADRP,
      OP_ADD12,
      OP_LDST8,
      OP_LDST32,
      OP_LDST64,
      OP_UNKNOWN
   } op_type;

   typedef struct packed {
      logic [63:0]        module_base;
      logic [63:0]        section_offset;
      logic [63:0]        entry_offset;
      logic [31:0]        reloc_type;
      logic [63:0]        symbol_address;
      logic signed [63:0] addend;
      logic [31:0]        old_instruction;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] patch_address;
      logic [63:0] write_value;
      logic [3:0]  write_bytes;
      logic [1:0]  status;
   } rsp_payload_type;

   // classified item held between front and back
   typedef struct packed {
      logic [63:0] place;
      logic [63:0] sym_plus_add;
      logic [31:0] insn;
      op_type      op;
   } entry_type;

endpackage

FILE: src/erpu_front.sv
// ----------------------------------------------------------------------------
// erpu_front
// accepts relocation items, forms P and S+A and decodes the type
// ----------------------------------------------------------------------------
module erpu_front import erpu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            out_valid,
   output entry_type       out_entry,
   input  logic            out_ready
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      load;
   op_type    op;

   always_comb begin
      unique case (req_payload.reloc_type) inside
         RT_X86_64_NONE:                                     op = OP_NONE;
         RT_X86_64_64, RT_A64_ABS64, RT_A64_RELATIVE:        op = OP_ABS64;
         RT_X86_64_PC64:                                     op = OP_PC64;
         RT_X86_64_32, RT_A64_ABS32:                         op = OP_ABS32U;
         RT_X86_64_32S:                                      op = OP_ABS32S;
         RT_X86_64_PC32, RT_X86_64_PLT32, RT_A64_PREL32:     op = OP_PC32;
         RT_A64_JUMP26, RT_A64_CALL26:                       op = OP_BR26;
         RT_A64_CONDBR19:                                    op = OP_BR19;
         RT_A64_ADR_PG_HI21:                                 op = OP_ADRP;
         RT_A64_ADD_LO12:                                    op = OP_ADD12;
         RT_A64_LDST8_LO12:                                  op = OP_LDST8;
         RT_A64_LDST32_LO12:                                 op = OP_LDST32;
         RT_A64_LDST64_LO12:                                 op = OP_LDST64;
         default:                                            op = OP_UNKNOWN;
      endcase
   end

   // the stage reloads when empty or when its item moves into the queue
   assign load      = !valid_ff || out_ready;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (load) begin
         valid_in              = req_valid;
         entry_in.place        = req_payload.module_base + req_payload.section_offset
                                 + req_payload.entry_offset;
         entry_in.sym_plus_add = req_payload.symbol_address + req_payload.addend;
         entry_in.insn         = req_payload.old_instruction;
         entry_in.op           = op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

FILE: src/erpu_queue.sv
// ----------------------------------------------------------------------------
// erpu_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module erpu_queue import erpu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_take,
   output entry_type pop_entry
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_take && pop_valid;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // a push alone raises the fill level by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not follow push");

   // pointers meet whenever the queue is empty or full
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

FILE: src/erpu_back.sv
// ----------------------------------------------------------------------------
// erpu_back
// forms the relative values, checks range and alignment, builds the patch
// ----------------------------------------------------------------------------
module erpu_back import erpu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_take,
   input  entry_type       in_entry,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type result_ff, result_in;

   logic [63:0] rel;
   logic [51:0] page_diff;
   logic [63:0] sa;
   logic [31:0] insn;
   logic        sa_s32_ok, sa_u32_ok, rel_s32_ok, rel_s28_ok, rel_s21_ok, page_ok;
   logic [63:0] val;
   logic [3:0]  bytes;
   status_type  st;

   function automatic logic [31:0] put_lo12(input logic [31:0] word, input logic [11:0] imm);
      return {word[31:22], imm, word[9:0]};
   endfunction

   assign sa   = in_entry.sym_plus_add;
   assign insn = in_entry.insn;
   assign rel  = sa - in_entry.place;
   assign page_diff = sa[63:12] - in_entry.place[63:12];

   // u32: top half zero; signed fit: all bits from the sign position up agree
   assign sa_u32_ok  = ~|sa[63:32];
   assign sa_s32_ok  = (&sa[63:31]) | ~|sa[63:31];
   assign rel_s32_ok = (&rel[63:31]) | ~|rel[63:31];
   assign rel_s28_ok = (&rel[63:27]) | ~|rel[63:27];
   assign rel_s21_ok = (&rel[63:20]) | ~|rel[63:20];
   assign page_ok    = (&page_diff[51:20]) | ~|page_diff[51:20];

   always_comb begin
      val   = '0;
      bytes = BYTES_NONE;
      st    = ST_OK;
      unique case (in_entry.op)
         OP_NONE: begin
         end
         OP_ABS64: begin
            val   = sa;
            bytes = BYTES_DWORD;
         end
         OP_PC64: begin
            val   = rel;
            bytes = BYTES_DWORD;
         end
         OP_ABS32U: begin
            if (!sa_u32_ok) st = ST_RANGE;
            val   = {32'd0, sa[31:0]};
            bytes = BYTES_WORD;
         end
         OP_ABS32S: begin
            if (!sa_s32_ok) st = ST_RANGE;
            val   = {32'd0, sa[31:0]};
            bytes = BYTES_WORD;
         end
         OP_PC32: begin
            if (!rel_s32_ok) st = ST_RANGE;
            val   = {32'd0, rel[31:0]};
            bytes = BYTES_WORD;
         end
         OP_BR26: begin
            if (rel[1:0] != 2'b00) st = ST_ALIGN;
            else if (!rel_s28_ok)  st = ST_RANGE;
            val   = {32'd0, insn[31:26], rel[27:2]};
            bytes = BYTES_WORD;
         end
         OP_BR19: begin
            if (rel[1:0] != 2'b00) st = ST_ALIGN;
            else if (!rel_s21_ok)  st = ST_RANGE;
            val   = {32'd0, insn[31:24], rel[20:2], insn[4:0]};
            bytes = BYTES_WORD;
         end
         OP_ADRP: begin
            if (!page_ok) st = ST_RANGE;
            val   = {32'd0, insn[31], page_diff[1:0], insn[28:24], page_diff[20:2], insn[4:0]};
            bytes = BYTES_WORD;
         end
         OP_ADD12: begin
            val   = {32'd0, put_lo12(insn, sa[11:0])};
            bytes = BYTES_WORD;
         end
         OP_LDST8: begin
            val   = {32'd0, put_lo12(insn, sa[11:0])};
            bytes = BYTES_WORD;
         end
         OP_LDST32: begin
            if (sa[1:0] != 2'b00) st = ST_ALIGN;
            val   = {32'd0, put_lo12(insn, {2'b00, sa[11:2]})};
            bytes = BYTES_WORD;
         end
         OP_LDST64: begin
            if (sa[2:0] != 3'b000) st = ST_ALIGN;
            val   = {32'd0, put_lo12(insn, {3'b000, sa[11:3]})};
            bytes = BYTES_WORD;
         end
         default: begin
            st = ST_UNKNOWN;
         end
      endcase
      // any failure suppresses the store
      if (st != ST_OK) begin
         val   = '0;
         bytes = BYTES_NONE;
      end
   end

   assign in_take = in_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in                = in_valid;
         result_in.patch_address = in_entry.place;
         result_in.write_value   = val;
         result_in.write_bytes   = bytes;
         result_in.status        = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = result_ff;

endmodule

FILE: src/elf_relocation_patch_unit_core.sv
// ----------------------------------------------------------------------------
// elf_relocation_patch_unit_core
// computes the memory patch for one elf relocation item (x86-64 and aarch64)
// ----------------------------------------------------------------------------
// The unit takes one relocation item per clock while req_stall is low and
// returns one result item for each, in order. When nothing stalls, an item
// passes the front stage register (place P and S+A adders, type decode),
// then the two-entry queue, and then the back stage (S+A-P, page
// difference, range and alignment checks, field insert) loads it into the
// result register, which offers it on the result port. Sustained rate is
// one item per cycle when the result side does not stall; while the result
// side stalls the front register, the two queue entries and the result
// register hold up to four items before the request side stalls. Failures
// give a status with a zero-byte, zero-value write and still report P.
// ----------------------------------------------------------------------------
module elf_relocation_patch_unit_core import erpu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   // relocation items in
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // patch items out
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // front to queue
   logic      front_valid;
   logic      queue_ready;
   entry_type front_entry;

   // queue to back
   logic      queue_valid;
   logic      back_take;
   entry_type queue_entry;

   // accept, add up P and S+A, classify the relocation type
   erpu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_valid   (front_valid),
      .out_entry   (front_entry),
      .out_ready   (queue_ready)
   );

   // decouples the decode side from the result side
   erpu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_take   (back_take),
      .pop_entry  (queue_entry)
   );

   // checks and patch value, registered result
   erpu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_take     (back_take),
      .in_entry    (queue_entry),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
